FILE: sv/pes_pkg.sv
package pes_pkg;

    localparam int TABLE_DEPTH = 16;

    localparam logic [1:0] ST_STORED  = 2'd0;
    localparam logic [1:0] ST_SKIPPED = 2'd1;
    localparam logic [1:0] ST_DROPPED = 2'd2;

    localparam logic [31:0] RECIP_NUM = 32'hffffffff;
    localparam logic [31:0] ONE_ROW   = 32'h00010000;
    localparam logic [15:0] FRAC_MASK = 16'hffff;

    // classified edge handed from front to back
    typedef struct packed {
        logic        new_poly;
        logic        skip;
        logic [15:0] top_row;
        logic [15:0] bot_row;
        logic [31:0] dy;
        logic [15:0] frac;
        logic [31:0] tx;
        logic [31:0] tu;
        logic [31:0] tv;
        logic [31:0] dx;
        logic [31:0] du;
        logic [31:0] dv;
    } t_edge;

endpackage

FILE: sv/polygon_edge_setup.sv
// Polygon edge setup. Each pushed beat is one edge (two 16.16 vertices with
// u and v); each popped beat reports whether it was stored, skipped as
// horizontal, or dropped with the table full, with steps, prestepped starts
// and the polygon's row span. A front stage orders the endpoints and forms
// the differences into a two-entry queue; the back unit runs a restoring
// divide (one quotient bit a cycle) then six products on one shared 32x32
// multiplier. The back takes a new edge only from idle, once the previous
// result beat has been popped; a skipped edge or one under one row high
// skips the divide.
// The per-edge table has no reset and is write-only.
module polygon_edge_setup
    import pes_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_new_polygon,
    input  logic [31:0] i_first_x,
    input  logic [31:0] i_first_y,
    input  logic [31:0] i_first_u,
    input  logic [31:0] i_first_v,
    input  logic [31:0] i_second_x,
    input  logic [31:0] i_second_y,
    input  logic [31:0] i_second_u,
    input  logic [31:0] i_second_v,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_status,
    output logic [3:0]  o_edge_slot,
    output logic [15:0] o_top_row,
    output logic [15:0] o_bottom_row,
    output logic [31:0] o_start_x,
    output logic [31:0] o_start_u,
    output logic [31:0] o_start_v,
    output logic [31:0] o_step_x,
    output logic [31:0] o_step_u,
    output logic [31:0] o_step_v,
    output logic [15:0] o_span_top,
    output logic [15:0] o_span_bottom
);
    logic  q_valid, q_take;
    t_edge q_edge;

    // front: classify and queue
    pes_front u_front (
        .i_clk, .i_rst_n, .i_push(push), .o_full(full),
        .i_new_polygon, .i_first_x, .i_first_y, .i_first_u, .i_first_v,
        .i_second_x, .i_second_y, .i_second_u, .i_second_v,
        .o_valid(q_valid), .o_edge(q_edge), .i_take(q_take));

    // back: divide, multiply, table update, result beat
    pes_back u_back (
        .i_clk, .i_rst_n, .i_valid(q_valid), .i_edge(q_edge), .o_take(q_take),
        .o_empty(empty), .i_pop(pop), .o_status, .o_edge_slot, .o_top_row,
        .o_bottom_row, .o_start_x, .o_start_u, .o_start_v, .o_step_x,
        .o_step_u, .o_step_v, .o_span_top, .o_span_bottom);
endmodule

FILE: sv/pes_front.sv
module pes_front
    import pes_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic        i_new_polygon,
    input  logic [31:0] i_first_x,
    input  logic [31:0] i_first_y,
    input  logic [31:0] i_first_u,
    input  logic [31:0] i_first_v,
    input  logic [31:0] i_second_x,
    input  logic [31:0] i_second_y,
    input  logic [31:0] i_second_u,
    input  logic [31:0] i_second_v,
    output logic        o_valid,
    output t_edge       o_edge,
    input  logic        i_take
);
    // two-entry queue toward the back part
    t_edge r_q [2];
    logic  r_wp, r_rp;
    logic [1:0] r_cnt;
    t_edge n_e;
    logic  swap;
    logic  acc, tak;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_edge  = r_q[r_rp];
    assign acc = i_push && !o_full;
    assign tak = i_take && o_valid;

    always_comb begin
        swap = $signed(i_second_y) < $signed(i_first_y);
        n_e.new_poly = i_new_polygon;
        n_e.skip     = (i_first_y[31:16] == i_second_y[31:16]);
        n_e.top_row  = swap ? i_second_y[31:16] : i_first_y[31:16];
        n_e.bot_row  = swap ? i_first_y[31:16] : i_second_y[31:16];
        n_e.tx = swap ? i_second_x : i_first_x;
        n_e.tu = swap ? i_second_u : i_first_u;
        n_e.tv = swap ? i_second_v : i_first_v;
        n_e.dy = swap ? i_first_y - i_second_y : i_second_y - i_first_y;
        n_e.dx = swap ? i_first_x - i_second_x : i_second_x - i_first_x;
        n_e.du = swap ? i_first_u - i_second_u : i_second_u - i_first_u;
        n_e.dv = swap ? i_first_v - i_second_v : i_second_v - i_first_v;
        n_e.frac = (swap ? i_second_y[15:0] : i_first_y[15:0]) ^ FRAC_MASK;
    end

    always_ff @(posedge i_clk) begin
        if (acc) r_q[r_wp] <= n_e;
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (acc) r_wp <= ~r_wp;
            if (tak) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, acc} - {1'b0, tak};
        end
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count overflow");
    a_no_take_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0) |=> (r_cnt <= 2'd1)) else $error("queue underflow");
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd1) |-> (r_wp != r_rp)) else $error("pointer mismatch");
`endif
endmodule

FILE: sv/pes_ram.sv
module pes_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_addr] <= i_wdata;
        o_rdata <= r_mem[i_addr];
    end
endmodule

FILE: sv/pes_back.sv
module pes_back
    import pes_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_edge       i_edge,
    output logic        o_take,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [1:0]  o_status,
    output logic [3:0]  o_edge_slot,
    output logic [15:0] o_top_row,
    output logic [15:0] o_bottom_row,
    output logic [31:0] o_start_x,
    output logic [31:0] o_start_u,
    output logic [31:0] o_start_v,
    output logic [31:0] o_step_x,
    output logic [31:0] o_step_u,
    output logic [31:0] o_step_v,
    output logic [15:0] o_span_top,
    output logic [15:0] o_span_bottom
);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int AW = $clog2(TABLE_DEPTH);

    typedef enum logic [2:0] {S_IDLE, S_DIV, S_MUL, S_PRE, S_DONE, S_OUT} t_state;

    t_state      r_state;
    t_edge       r_e;
    logic [31:0] r_rem, r_quo, r_den;
    logic [5:0]  r_bit;
    logic [1:0]  r_lane;
    logic [31:0] r_step [3];
    logic [31:0] r_start [3];
    logic [CW-1:0] r_count;
    logic [15:0] r_lo, r_hi;
    logic        r_we;
    logic [AW-1:0] r_addr;

    logic [32:0] rem_sh;
    logic        ge;
    logic [63:0] prod;
    logic signed [31:0] ma, mb;
    logic [31:0] rows_q;
    logic [63:0] x_q, u_q, v_q;
    logic [15:0] lo_c, hi_c;
    logic [CW-1:0] cnt_c;

    assign o_take  = (r_state == S_IDLE) && i_valid;
    assign o_empty = (r_state != S_OUT);
    assign rem_sh  = {r_rem, r_den[31]};
    assign ge      = rem_sh >= {1'b0, r_e.dy};

    // one shared 32x32 signed multiplier
    always_comb begin
        if (r_state == S_MUL) begin
            ma = $signed(r_quo);
            case (r_lane)
                2'd0:    mb = $signed(r_e.dx);
                2'd1:    mb = $signed(r_e.du);
                default: mb = $signed(r_e.dv);
            endcase
        end else begin
            ma = $signed({16'd0, r_e.frac});
            mb = $signed(r_step[r_lane]);
        end
        prod = 64'(ma * mb);
    end

    always_comb begin
        lo_c = r_e.new_poly ? 16'sh7fff : r_lo;
        hi_c = r_e.new_poly ? 16'sh8000 : r_hi;
        cnt_c = r_e.new_poly ? '0 : r_count;
    end

    always_ff @(posedge i_clk) begin
        r_we <= i_rst_n && (r_state == S_DONE) && !r_e.skip
                && (cnt_c < CW'(TABLE_DEPTH));
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_lo <= 16'sh7fff;
            r_hi <= 16'sh8000;
        end else begin
            case (r_state)
                S_IDLE: if (i_valid) begin
                    r_e <= i_edge;
                    r_rem <= '0; r_quo <= '0; r_den <= RECIP_NUM;
                    r_bit <= 6'd0; r_lane <= 2'd0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    // restoring divide, one quotient bit a cycle
                    if (r_e.dy < ONE_ROW || r_e.skip) begin
                        r_quo <= '0;
                        r_state <= S_MUL;
                    end else begin
                        r_rem <= ge ? 32'(rem_sh - {1'b0, r_e.dy}) : rem_sh[31:0];
                        r_quo <= {r_quo[30:0], ge};
                        r_den <= {r_den[30:0], 1'b0};
                        r_bit <= r_bit + 6'd1;
                        if (r_bit == 6'd31) r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_step[r_lane] <= prod[47:16];
                    if (r_lane == 2'd2) begin
                        r_lane <= 2'd0; r_state <= S_PRE;
                    end else r_lane <= r_lane + 2'd1;
                end
                S_PRE: begin
                    case (r_lane)
                        2'd0:    r_start[0] <= r_e.tx + prod[47:16];
                        2'd1:    r_start[1] <= r_e.tu + prod[47:16];
                        default: r_start[2] <= r_e.tv + prod[47:16];
                    endcase
                    if (r_lane == 2'd2) r_state <= S_DONE;
                    else r_lane <= r_lane + 2'd1;
                end
                S_DONE: begin
                    o_top_row <= r_e.top_row;
                    o_bottom_row <= r_e.bot_row;
                    if (r_e.skip) begin
                        o_status <= ST_SKIPPED;
                        o_edge_slot <= '0;
                        {o_start_x, o_start_u, o_start_v} <= '0;
                        {o_step_x, o_step_u, o_step_v} <= '0;
                        r_lo <= lo_c; r_hi <= hi_c; r_count <= cnt_c;
                        o_span_top <= lo_c; o_span_bottom <= hi_c;
                    end else begin
                        o_start_x <= r_start[0]; o_start_u <= r_start[1];
                        o_start_v <= r_start[2];
                        o_step_x <= r_step[0]; o_step_u <= r_step[1];
                        o_step_v <= r_step[2];
                        if (cnt_c >= CW'(TABLE_DEPTH)) begin
                            o_status <= ST_DROPPED;
                            o_edge_slot <= '0;
                            r_lo <= lo_c; r_hi <= hi_c; r_count <= cnt_c;
                            o_span_top <= lo_c; o_span_bottom <= hi_c;
                        end else begin
                            o_status <= ST_STORED;
                            o_edge_slot <= 4'(cnt_c);
                            r_addr <= cnt_c[AW-1:0];
                            r_count <= cnt_c + CW'(1);
                            r_lo <= ($signed(r_e.top_row) < $signed(lo_c)) ? r_e.top_row : lo_c;
                            r_hi <= ($signed(r_e.bot_row) > $signed(hi_c)) ? r_e.bot_row : hi_c;
                            o_span_top <= ($signed(r_e.top_row) < $signed(lo_c))
                                ? r_e.top_row : lo_c;
                            o_span_bottom <= ($signed(r_e.bot_row) > $signed(hi_c))
                                ? r_e.bot_row : hi_c;
                        end
                    end
                    r_state <= S_OUT;
                end
                S_OUT: if (i_pop) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // edge table, written once per stored edge
    pes_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_rows (
        .i_clk, .i_we(r_we), .i_addr(r_addr),
        .i_wdata({o_bottom_row, o_top_row}), .o_rdata(rows_q));
    pes_ram #(.WIDTH(64), .DEPTH(TABLE_DEPTH)) u_x (
        .i_clk, .i_we(r_we), .i_addr(r_addr),
        .i_wdata({o_step_x, o_start_x}), .o_rdata(x_q));
    pes_ram #(.WIDTH(64), .DEPTH(TABLE_DEPTH)) u_u (
        .i_clk, .i_we(r_we), .i_addr(r_addr),
        .i_wdata({o_step_u, o_start_u}), .o_rdata(u_q));
    pes_ram #(.WIDTH(64), .DEPTH(TABLE_DEPTH)) u_v (
        .i_clk, .i_we(r_we), .i_addr(r_addr),
        .i_wdata({o_step_v, o_start_v}), .o_rdata(v_q));

`ifndef SYNTHESIS
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH)) else $error("edge count past table");
    a_we_stored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_we |-> (o_status == ST_STORED)) else $error("write without store");
    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take |=> (r_state == S_DIV)) else $error("take not followed by divide");
`endif
endmodule
